@@ rtl/mfps_pkg.sv @@
// Shared definitions for the multi-format pixel store: format codes, operation codes,
// register indexes and the byte-lane arrangement of the pixel memory.
// No dependencies.
package mfps_pkg;

  typedef logic [2:0] fmt_t;
  typedef logic [1:0] reg_idx_t;

  localparam fmt_t FMT_BIT1  = 3'd0;
  localparam fmt_t FMT_BYTE1 = 3'd1;
  localparam fmt_t FMT_BYTE2 = 3'd2;
  localparam fmt_t FMT_BYTE3 = 3'd3;
  localparam fmt_t FMT_BYTE4 = 3'd4;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam reg_idx_t REG_FORMAT = 2'd0;
  localparam reg_idx_t REG_WIDTH  = 2'd1;
  localparam reg_idx_t REG_HEIGHT = 2'd2;

  // The memory is split into four byte lanes so that any pixel of up to four bytes
  // can be served in one access.
  localparam int unsigned LANES     = 4;
  localparam int unsigned LANE_BITS = 2;

  // Number of bytes a pixel touches; a one-bit pixel touches a single byte.
  function automatic logic [2:0] bytes_per_pixel(fmt_t fmt);
    logic [2:0] n;
    case (fmt)
      FMT_BIT1:  n = 3'd1;
      FMT_BYTE1: n = 3'd1;
      FMT_BYTE2: n = 3'd2;
      FMT_BYTE3: n = 3'd3;
      FMT_BYTE4: n = 3'd4;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/multi_format_pixel_store.sv @@
// Multi-format pixel store: a frame buffer in four byte-lane RAMs (mfps_ram), using mfps_pkg.
// One request at a time: address multiply, offset add, byte scaling, memory access, data.
// A read passes the multiply, add, scale, access and data states before its result is
// registered; a one-bit write reads at access and writes back at data (read-modify-write),
// a multi-byte write ends at access. After reset a clearing pass zeroes one row of all lanes
// per cycle over all BANK_DEPTH rows, taking no request; configuration writes are always taken.
module multi_format_pixel_store #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [31:0] write_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_value_o,
  output logic        in_bounds_o
);

  localparam int unsigned NL         = mfps_pkg::LANES;
  localparam int unsigned BANK_DEPTH = (MEM_BYTES + NL - 1) / NL;
  localparam int unsigned RW         = $clog2(BANK_DEPTH);
  localparam int unsigned ABITS      = $clog2(MEM_BYTES);
  localparam logic [35:0] MEM_LIMIT  = 36'(MEM_BYTES);
  localparam logic [RW-1:0] LAST_ROW = RW'(BANK_DEPTH - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_SCALE  = 3'd4;
  localparam logic [2:0] S_ACCESS = 3'd5;
  localparam logic [2:0] S_DATA   = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [RW-1:0]        clr_q, clr_d;
  mfps_pkg::fmt_t       fmt_q;
  logic [15:0]          width_q, height_q;

  logic                 op_q;
  logic [15:0]          x_q, y_q;
  logic [31:0]          wval_q;
  logic [31:0]          prod_q;
  logic                 coord_ok_q;
  logic [32:0]          sum_q;
  logic [ABITS-1:0]     addr_q;
  logic                 ok_q;

  logic                 out_valid_q;
  logic [31:0]          read_value_q;
  logic                 in_bounds_q;

  logic [15:0]          row_len;
  logic [15:0]          x_off;
  logic [2:0]           npix;
  logic [34:0]          scaled;
  logic [35:0]          end_addr;
  logic [1:0]           lane_off;
  logic [RW-1:0]        base_row;
  logic [RW-1:0]        lane_row [NL];
  logic [1:0]           lane_rel [NL];
  logic                 lane_used [NL];
  logic                 ram_we [NL];
  logic [RW-1:0]        ram_waddr [NL];
  logic [7:0]           ram_wdata [NL];
  logic                 ram_re;
  logic [7:0]           ram_rdata [NL];
  logic [7:0]           mod_byte;
  logic [31:0]          read_val;
  logic                 out_free;
  logic                 load_out;
  logic                 in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign load_out    = (state_q == S_DATA) && (op_q == mfps_pkg::OP_READ) && out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= mfps_pkg::FMT_BIT1;
      width_q  <= 16'd0;
      height_q <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mfps_pkg::REG_FORMAT: fmt_q    <= cfg_data_i[2:0];
        mfps_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        mfps_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Address arithmetic.
  always_comb begin
    npix    = mfps_pkg::bytes_per_pixel(fmt_q);
    row_len = (fmt_q == mfps_pkg::FMT_BIT1) ? 16'((17'(width_q) + 17'd7) >> 3) : width_q;
    x_off   = (fmt_q == mfps_pkg::FMT_BIT1) ? (x_q >> 3) : x_q;
    case (fmt_q)
      mfps_pkg::FMT_BYTE2: scaled = 35'(sum_q) << 1;
      mfps_pkg::FMT_BYTE3: scaled = 35'(sum_q) + (35'(sum_q) << 1);
      mfps_pkg::FMT_BYTE4: scaled = 35'(sum_q) << 2;
      default:             scaled = 35'(sum_q);
    endcase
    end_addr = 36'(scaled) + 36'(npix);
  end

  // Lane mapping: byte i of the pixel sits in lane (offset + i) mod 4, one row further
  // on for lanes below the starting lane.
  always_comb begin
    lane_off = addr_q[1:0];
    base_row = RW'(addr_q >> 2);
    for (int l = 0; l < NL; l++) begin
      lane_rel[l]  = 2'(l) - lane_off;
      lane_row[l]  = base_row + RW'(2'(l) < lane_off);
      lane_used[l] = (3'(lane_rel[l]) < npix);
    end
  end

  // Read assembly and the one-bit merge.
  always_comb begin
    read_val = 32'd0;
    mod_byte = ram_rdata[lane_off];
    mod_byte[x_q[2:0]] = wval_q[0];
    if (ok_q) begin
      if (fmt_q == mfps_pkg::FMT_BIT1) begin
        read_val = {31'd0, ram_rdata[lane_off][x_q[2:0]]};
      end else begin
        for (int i = 0; i < NL; i++) begin
          if (3'(i) < npix) begin
            read_val[8*i +: 8] = ram_rdata[2'(lane_off + 2'(i))];
          end
        end
      end
    end
  end

  // Memory ports.
  always_comb begin
    ram_re = (state_q == S_ACCESS) && ok_q &&
             ((op_q == mfps_pkg::OP_READ) || (fmt_q == mfps_pkg::FMT_BIT1));
    for (int l = 0; l < NL; l++) begin
      ram_we[l]    = 1'b0;
      ram_waddr[l] = lane_row[l];
      ram_wdata[l] = 8'(wval_q >> (8 * lane_rel[l]));
      if (state_q == S_CLEAR) begin
        ram_we[l]    = 1'b1;
        ram_waddr[l] = clr_q;
        ram_wdata[l] = 8'h00;
      end else if (state_q == S_ACCESS) begin
        ram_we[l] = ok_q && (op_q == mfps_pkg::OP_WRITE) &&
                    (fmt_q != mfps_pkg::FMT_BIT1) && lane_used[l];
      end else if (state_q == S_DATA) begin
        if (ok_q && (op_q == mfps_pkg::OP_WRITE) && (fmt_q == mfps_pkg::FMT_BIT1) &&
            (2'(l) == lane_off)) begin
          ram_we[l]    = 1'b1;
          ram_wdata[l] = mod_byte;
        end
      end
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    mfps_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (ram_waddr[g]),
      .wdata_i (ram_wdata[g]),
      .re_i    (ram_re),
      .raddr_i (lane_row[g]),
      .rdata_o (ram_rdata[g])
    );
  end

  // Sequencer. Only one request is in flight, so a write always lands before the next
  // request reads the memory.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + RW'(1);
        if (clr_q == LAST_ROW) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_MUL;
        end
      end
      S_MUL:    state_d = S_SUM;
      S_SUM:    state_d = S_SCALE;
      S_SCALE:  state_d = S_ACCESS;
      S_ACCESS: begin
        if ((op_q == mfps_pkg::OP_WRITE) && (fmt_q != mfps_pkg::FMT_BIT1 || !ok_q)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        if ((op_q == mfps_pkg::OP_WRITE) || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= operation_i;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      wval_q <= write_value_i;
    end
    if (state_q == S_MUL) begin
      prod_q     <= y_q * row_len;
      coord_ok_q <= (x_q < width_q) && (y_q < height_q) && (fmt_q <= mfps_pkg::FMT_BYTE4);
    end
    if (state_q == S_SUM) begin
      sum_q <= 33'(prod_q) + 33'(x_off);
    end
    if (state_q == S_SCALE) begin
      addr_q <= ABITS'(scaled);
      ok_q   <= coord_ok_q && (end_addr <= MEM_LIMIT);
    end
    if (load_out) begin
      read_value_q <= read_val;
      in_bounds_q  <= ok_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign in_bounds_o  = in_bounds_q;

  // A rejected read always reports zero.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_bounds_o |-> read_value_o == 32'd0)
    else $error("rejected read returned a non-zero value");

  // A one-bit read returns a single bit.
  a_bit_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_bounds_o && (fmt_q == mfps_pkg::FMT_BIT1) |-> read_value_o[31:1] == 31'd0)
    else $error("one-bit read returned more than one bit");

  // A read request never writes the memory.
  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCESS || state_q == S_DATA) && (op_q == mfps_pkg::OP_READ) |->
      !(ram_we[0] || ram_we[1] || ram_we[2] || ram_we[3]))
    else $error("memory written during a read request");

  // No request is taken while the clearing pass runs.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o)
    else $error("request accepted during the clearing pass");

  // A finished read beat is not dropped: leaving the data stage on a read loads the output.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) && (op_q == mfps_pkg::OP_READ) && (state_d == S_IDLE) |=> out_valid_o)
    else $error("read result lost");

endmodule

@@ rtl/mfps_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module mfps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
